// ===== hw/rtl/sfb_pkg.sv =====
// Shared constants and types for the screen fade brightness block.
`default_nettype none

package sfb_pkg;

    typedef logic [31:0] word_t;

    localparam int TIME_W   = 32;
    localparam int LEVEL_W  = 8;
    localparam int TICKS_W  = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [TICKS_W-1:0] PERMILLE     = 16'd1000;
    localparam logic [LEVEL_W-1:0] CHARGE_LEVEL = 8'd40;

    localparam logic [LEVEL_W-1:0] TARGET_RESET   = 8'd255;
    localparam logic [TICKS_W-1:0] FADE_IN_RESET  = 16'd100;
    localparam logic [TICKS_W-1:0] FADE_OUT_RESET = 16'd100;

    localparam logic [CFG_IDX_W-1:0] CFG_TARGET   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_IN  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE_OUT = 2'd2;

endpackage

`default_nettype wire

// ===== hw/rtl/screen_fade_brightness.sv =====
// Display brightness fader top level with shared multiplier and divider.
//
//  channel   direction  beat contents
//  s_        in         tdata: now_time, screen_off_deadline; tuser: flags
//  m_        out        tdata: contrast_level
//  cfg_      in         cfg_index selects register, cfg_data carries value
//
// The shared divider retires two quotient bits a cycle, and a ramp with
// deadline update runs four divisions in sequence.
// Reset clears the registers to their defaults and the fade state to zero.
// s_tready is high only while idle; a result waiting on m_tready does not
// block the next accept, but a second result waits until the first leaves.
`default_nettype none

module screen_fade_brightness (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [63:0]                    s_tdata,  // now_time, screen_off_deadline
    input  wire logic [2:0]                     s_tuser,  // is_charging, pause_off, restart_fade
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [7:0]                          m_tdata,  // contrast_level
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [sfb_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [sfb_pkg::TICKS_W-1:0]    cfg_data
);

    localparam logic [3:0] S_IDLE = 4'd0;
    localparam logic [3:0] S_PREP = 4'd1;
    localparam logic [3:0] S_MUL1 = 4'd2;
    localparam logic [3:0] S_DIV  = 4'd3;
    localparam logic [3:0] S_MUL2 = 4'd4;
    localparam logic [3:0] S_LVL  = 4'd5;
    localparam logic [3:0] S_TAIL = 4'd6;
    localparam logic [3:0] S_MUL4 = 4'd7;
    localparam logic [3:0] S_DL   = 4'd8;
    localparam logic [3:0] S_DONE = 4'd9;

    logic [3:0]                      state_reg, state_next;
    logic [3:0]                      ret_reg, ret_next;
    sfb_pkg::word_t                  now_reg, now_next;
    sfb_pkg::word_t                  off_reg, off_next;
    logic                            charging_reg, charging_next;
    logic                            paused_reg, paused_next;
    logic                            charge_reg, charge_next;
    sfb_pkg::word_t                  deadline_reg, deadline_next;
    logic [sfb_pkg::LEVEL_W-1:0]     level_reg, level_next;
    logic [sfb_pkg::TICKS_W-1:0]     div_rem_reg, div_rem_next;
    sfb_pkg::word_t                  div_quo_reg, div_quo_next;
    logic [sfb_pkg::TICKS_W-1:0]     div_den_reg, div_den_next;
    logic [3:0]                      div_cnt_reg, div_cnt_next;
    logic                            out_valid_reg, out_valid_next;
    logic [sfb_pkg::LEVEL_W-1:0]     out_data_reg, out_data_next;
    logic [sfb_pkg::LEVEL_W-1:0]     target_reg;
    logic [sfb_pkg::TICKS_W-1:0]     fin_reg;
    logic [sfb_pkg::TICKS_W-1:0]     fout_reg;

    logic [sfb_pkg::LEVEL_W-1:0]     target;
    logic [sfb_pkg::TICKS_W-1:0]     fin;
    logic [sfb_pkg::TICKS_W-1:0]     fout;

    sfb_pkg::word_t                  mul_a;
    logic [sfb_pkg::TICKS_W-1:0]     mul_b;
    logic [47:0]                     mul_full;
    sfb_pkg::word_t                  mul_p;

    logic [16:0]                     r1, r2;
    logic                            ge1, ge2;
    logic [15:0]                     rem1, rem2;
    sfb_pkg::word_t                  quo1, quo2;

    sfb_pkg::word_t                  s_now, s_off, d0;
    sfb_pkg::word_t                  left, start, run;
    logic                            a_hit, b_hit, charge_now;

    assign target = (target_reg == '0) ? 8'd1 : target_reg;
    assign fin    = (fin_reg == '0) ? 16'd1 : fin_reg;
    assign fout   = (fout_reg == '0) ? 16'd1 : fout_reg;

    assign s_now = s_tdata[31:0];
    assign s_off = s_tdata[63:32];

    assign s_tready  = (state_reg == S_IDLE);
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign cfg_ready = 1'b1;

    assign mul_full = {16'd0, mul_a} * {32'd0, mul_b};
    assign mul_p    = mul_full[31:0];

    // two restoring divide steps per cycle
    always_comb
    begin
        r1   = {div_rem_reg, div_quo_reg[31]};
        ge1  = (r1 >= {1'b0, div_den_reg});
        rem1 = ge1 ? 16'(r1 - {1'b0, div_den_reg}) : r1[15:0];
        quo1 = {div_quo_reg[30:0], ge1};
        r2   = {rem1, quo1[31]};
        ge2  = (r2 >= {1'b0, div_den_reg});
        rem2 = ge2 ? 16'(r2 - {1'b0, div_den_reg}) : r2[15:0];
        quo2 = {quo1[30:0], ge2};
    end

    always_comb
    begin
        left       = off_reg - now_reg;
        start      = deadline_reg - {16'd0, fin};
        run        = now_reg - start;
        charge_now = charging_reg && !paused_reg && (off_reg < now_reg);
        a_hit      = !paused_reg && (off_reg >= now_reg) && (left <= {16'd0, fout});
        b_hit      = !charge_now && (deadline_reg != '0) && (now_reg <= deadline_reg);
        d0         = s_tuser[2] ? '0 : deadline_reg;
    end

    always_comb
    begin
        state_next     = state_reg;
        ret_next       = ret_reg;
        now_next       = now_reg;
        off_next       = off_reg;
        charging_next  = charging_reg;
        paused_next    = paused_reg;
        charge_next    = charge_reg;
        deadline_next  = deadline_reg;
        level_next     = level_reg;
        div_rem_next   = div_rem_reg;
        div_quo_next   = div_quo_reg;
        div_den_next   = div_den_reg;
        div_cnt_next   = div_cnt_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        mul_a          = div_quo_reg;
        mul_b          = sfb_pkg::PERMILLE;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    now_next      = s_now;
                    off_next      = s_off;
                    charging_next = s_tuser[0];
                    paused_next   = s_tuser[1];
                    deadline_next = (d0 == '0) ? s_now + {16'd0, fin} : d0;
                    state_next    = S_PREP;
                end
            end
            S_PREP:
            begin
                charge_next = charge_now;
                if (a_hit)
                begin
                    div_quo_next = left;
                    div_den_next = fout;
                    state_next   = S_MUL1;
                end
                else if (b_hit)
                begin
                    div_quo_next = run;
                    div_den_next = fin;
                    state_next   = S_MUL1;
                end
                else
                begin
                    if (charge_now)
                    begin
                        level_next = sfb_pkg::CHARGE_LEVEL;
                    end
                    state_next = S_TAIL;
                end
            end
            S_MUL1:
            begin
                div_quo_next = mul_p;
                div_rem_next = '0;
                div_cnt_next = '0;
                ret_next     = S_MUL2;
                state_next   = S_DIV;
            end
            S_DIV:
            begin
                div_rem_next = rem2;
                div_quo_next = quo2;
                div_cnt_next = div_cnt_reg + 4'd1;
                if (div_cnt_reg == 4'd15)
                begin
                    state_next = ret_reg;
                end
            end
            S_MUL2:
            begin
                mul_b        = {8'd0, target};
                div_quo_next = mul_p;
                div_den_next = sfb_pkg::PERMILLE;
                div_rem_next = '0;
                div_cnt_next = '0;
                ret_next     = S_LVL;
                state_next   = S_DIV;
            end
            S_LVL:
            begin
                level_next = div_quo_reg[7:0];
                state_next = S_TAIL;
            end
            S_TAIL:
            begin
                mul_a = {24'd0, level_reg};
                if ((level_reg <= target) && !charge_reg)
                begin
                    div_quo_next = mul_p;
                    div_den_next = {8'd0, target};
                    div_rem_next = '0;
                    div_cnt_next = '0;
                    ret_next     = S_MUL4;
                    state_next   = S_DIV;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_MUL4:
            begin
                mul_b        = fin;
                div_quo_next = mul_p;
                div_den_next = sfb_pkg::PERMILLE;
                div_rem_next = '0;
                div_cnt_next = '0;
                ret_next     = S_DL;
                state_next   = S_DIV;
            end
            S_DL:
            begin
                deadline_next = now_reg + ({16'd0, fin} - div_quo_reg);
                state_next    = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    out_valid_next = 1'b1;
                    out_data_next  = level_reg;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ret_reg       <= S_IDLE;
            deadline_reg  <= '0;
            level_reg     <= '0;
            out_valid_reg <= 1'b0;
            target_reg    <= sfb_pkg::TARGET_RESET;
            fin_reg       <= sfb_pkg::FADE_IN_RESET;
            fout_reg      <= sfb_pkg::FADE_OUT_RESET;
        end
        else
        begin
            state_reg     <= state_next;
            ret_reg       <= ret_next;
            deadline_reg  <= deadline_next;
            level_reg     <= level_next;
            out_valid_reg <= out_valid_next;
            if (cfg_valid)
            begin
                unique case (cfg_index)
                    sfb_pkg::CFG_TARGET:   target_reg <= cfg_data[7:0];
                    sfb_pkg::CFG_FADE_IN:  fin_reg    <= cfg_data;
                    sfb_pkg::CFG_FADE_OUT: fout_reg   <= cfg_data;
                    default:               ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        now_reg      <= now_next;
        off_reg      <= off_next;
        charging_reg <= charging_next;
        paused_reg   <= paused_next;
        charge_reg   <= charge_next;
        div_rem_reg  <= div_rem_next;
        div_quo_reg  <= div_quo_next;
        div_den_reg  <= div_den_next;
        div_cnt_reg  <= div_cnt_next;
        out_data_reg <= out_data_next;
    end

endmodule

`default_nettype wire
